[rtl/gne_pkg.sv]
// ----------------------------------------------------------------------------
// gne_pkg
// Shared constants, types and neighbor helpers for the grid neighbor block.
// ----------------------------------------------------------------------------
package gne_pkg;

   localparam int GridSize   = 32;
   localparam int StoreDepth = 1024;
   localparam int NumCells   = GridSize * GridSize;

   localparam int NodeW    = 10;
   localparam int AddrW    = $clog2(StoreDepth);
   localparam int CellW    = 17;
   localparam int IdxW     = 12;
   localparam int CostW    = 16;
   localparam int DirW     = 3;
   localparam int NumDirs  = 8;
   localparam int CsrAddrW = 3;
   localparam int CsrDataW = 32;

   localparam logic CmdWrite = 1'b0;
   localparam logic CmdQuery = 1'b1;

   localparam logic [IdxW-1:0]  CenterOff    = IdxW'(GridSize + 1);
   localparam logic [CostW-1:0] StraightInit = CostW'(16);
   localparam logic [CostW-1:0] DiagonalInit = CostW'(23);
   localparam logic [DirW-1:0]  LastDir      = DirW'(NumDirs - 1);

   typedef enum logic {
      CsrStraightCost = 1'b0,
      CsrDiagonalCost = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ScanClear,
      ScanIdle,
      ScanRead,
      ScanDone
   } scan_state_type;

   typedef struct packed {
      logic               valid;
      logic [NodeW-1:0]   node;
      logic [NumDirs-1:0] ok;
   } scan_result_type;

   // offset of a neighbor from the top-left corner of the 3x3 window
   function automatic logic [IdxW-1:0] neighbor_offset(input logic [DirW-1:0] dir);
      logic [IdxW-1:0] off;
      case (dir)
         3'd0: off = IdxW'(0);
         3'd1: off = IdxW'(1);
         3'd2: off = IdxW'(2);
         3'd3: off = IdxW'(GridSize);
         3'd4: off = IdxW'(GridSize + 2);
         3'd5: off = IdxW'(2 * GridSize);
         3'd6: off = IdxW'(2 * GridSize + 1);
         3'd7: off = IdxW'(2 * GridSize + 2);
         default: off = IdxW'(0);
      endcase
      return off;
   endfunction

   function automatic logic is_up(input logic [DirW-1:0] dir);
      return (dir == 3'd0) || (dir == 3'd1) || (dir == 3'd2);
   endfunction

   function automatic logic is_down(input logic [DirW-1:0] dir);
      return (dir == 3'd5) || (dir == 3'd6) || (dir == 3'd7);
   endfunction

   function automatic logic is_left(input logic [DirW-1:0] dir);
      return (dir == 3'd0) || (dir == 3'd3) || (dir == 3'd5);
   endfunction

   function automatic logic is_right(input logic [DirW-1:0] dir);
      return (dir == 3'd2) || (dir == 3'd4) || (dir == 3'd7);
   endfunction

   function automatic logic is_diag(input logic [DirW-1:0] dir);
      return (is_up(dir) || is_down(dir)) && (is_left(dir) || is_right(dir));
   endfunction

endpackage

[rtl/gne_if.sv]
// ----------------------------------------------------------------------------
// gne_req_if / gne_rsp_if
// Valid/ready channels for grid commands and neighbor results.
// ----------------------------------------------------------------------------
interface gne_req_if;
   logic                      valid;
   logic                      ready;
   logic                      command;
   logic [gne_pkg::NodeW-1:0] node;
   logic                      blocked;

   modport source(output valid, command, node, blocked, input ready);
   modport sink(input valid, command, node, blocked, output ready);
endinterface

interface gne_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [gne_pkg::DirW-1:0]  direction;
   logic                      valid_res;
   logic [gne_pkg::NodeW-1:0] to_node;
   logic [gne_pkg::CostW-1:0] step_cost;
   logic                      last;

   modport source(output valid, direction, valid_res, to_node, step_cost, last,
                  input ready);
   modport sink(input valid, direction, valid_res, to_node, step_cost, last,
                output ready);
endinterface

[rtl/gne_grid_scan.sv]
// ----------------------------------------------------------------------------
// gne_grid_scan
// Occupancy memory with clearing pass, cell writes and 8-neighbor query scan.
// ----------------------------------------------------------------------------
module gne_grid_scan (
   input  logic                     clock,
   input  logic                     reset,
   gne_req_if.sink                  req_ch,
   output gne_pkg::scan_result_type result,
   input  logic                     result_take
);

   gne_pkg::scan_state_type state_ff, state_in;

   logic [gne_pkg::AddrW-1:0]   clr_addr_ff, clr_addr_in;
   logic [gne_pkg::DirW-1:0]    rd_dir_ff, rd_dir_in;
   logic [gne_pkg::NodeW-1:0]   node_ff;
   logic                        inside_ff;
   logic                        cap_valid_ff;
   logic [gne_pkg::DirW-1:0]    cap_dir_ff;
   logic                        cap_ok_ff;
   logic [gne_pkg::NumDirs-1:0] free_ff;

   logic                        mem_ff [gne_pkg::StoreDepth];
   logic                        mem_q_ff;
   logic                        mem_we;
   logic [gne_pkg::AddrW-1:0]   mem_addr;
   logic                        mem_wdata;

   logic                        accept;
   logic                        req_inside;
   logic                        req_stored;
   logic [gne_pkg::NodeW-1:0]   row;
   logic [gne_pkg::NodeW-1:0]   col;
   logic [gne_pkg::IdxW-1:0]    rd_idx;
   logic                        coord_ok;

   assign req_ch.ready = (state_ff == gne_pkg::ScanIdle);
   assign accept       = req_ch.valid && req_ch.ready;
   assign req_inside   = gne_pkg::CellW'(req_ch.node) < gne_pkg::CellW'(gne_pkg::NumCells);
   assign req_stored   = gne_pkg::CellW'(req_ch.node) < gne_pkg::CellW'(gne_pkg::StoreDepth);

   // neighbor coordinates of the query node
   assign row    = gne_pkg::NodeW'(node_ff / gne_pkg::GridSize);
   assign col    = gne_pkg::NodeW'(node_ff % gne_pkg::GridSize);
   assign rd_idx = gne_pkg::IdxW'(node_ff) + gne_pkg::neighbor_offset(rd_dir_ff)
                   - gne_pkg::CenterOff;

   always_comb begin
      coord_ok = inside_ff;
      if (gne_pkg::is_up(rd_dir_ff) && (row == '0)) begin
         coord_ok = 1'b0;
      end
      if (gne_pkg::is_down(rd_dir_ff) && (row == gne_pkg::NodeW'(gne_pkg::GridSize - 1))) begin
         coord_ok = 1'b0;
      end
      if (gne_pkg::is_left(rd_dir_ff) && (col == '0)) begin
         coord_ok = 1'b0;
      end
      if (gne_pkg::is_right(rd_dir_ff) && (col == gne_pkg::NodeW'(gne_pkg::GridSize - 1))) begin
         coord_ok = 1'b0;
      end
      // cells past the end of the store count as blocked
      if (rd_idx >= gne_pkg::IdxW'(gne_pkg::StoreDepth)) begin
         coord_ok = 1'b0;
      end
   end

   // single memory port: clear sweep, cell write or neighbor read
   always_comb begin
      mem_we    = 1'b0;
      mem_wdata = 1'b0;
      mem_addr  = req_ch.node[gne_pkg::AddrW-1:0];
      case (state_ff)
         gne_pkg::ScanClear: begin
            mem_we   = 1'b1;
            mem_addr = clr_addr_ff;
         end
         gne_pkg::ScanRead: begin
            mem_addr = rd_idx[gne_pkg::AddrW-1:0];
         end
         gne_pkg::ScanIdle: begin
            mem_we    = accept && (req_ch.command == gne_pkg::CmdWrite) && req_inside
                        && req_stored;
            mem_wdata = req_ch.blocked;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_addr] <= mem_wdata;
      end
      mem_q_ff <= mem_ff[mem_addr];
   end

   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      rd_dir_in   = rd_dir_ff;
      case (state_ff)
         gne_pkg::ScanClear: begin
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == gne_pkg::AddrW'(gne_pkg::StoreDepth - 1)) begin
               state_in = gne_pkg::ScanIdle;
            end
         end
         gne_pkg::ScanIdle: begin
            rd_dir_in = '0;
            if (accept && (req_ch.command == gne_pkg::CmdQuery)) begin
               state_in = gne_pkg::ScanRead;
            end
         end
         gne_pkg::ScanRead: begin
            rd_dir_in = rd_dir_ff + 1'b1;
            if (rd_dir_ff == gne_pkg::LastDir) begin
               state_in = gne_pkg::ScanDone;
            end
         end
         gne_pkg::ScanDone: begin
            if (result_take) begin
               state_in = gne_pkg::ScanIdle;
            end
         end
         default: begin
            state_in = gne_pkg::ScanIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gne_pkg::ScanClear;
         clr_addr_ff  <= '0;
         rd_dir_ff    <= '0;
         cap_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rd_dir_ff    <= rd_dir_in;
         cap_valid_ff <= (state_ff == gne_pkg::ScanRead);
      end
   end

   always_ff @(posedge clock) begin
      if (accept && (req_ch.command == gne_pkg::CmdQuery)) begin
         node_ff   <= req_ch.node;
         inside_ff <= req_inside;
      end
      cap_dir_ff <= rd_dir_ff;
      cap_ok_ff  <= coord_ok;
      // read data lands in the cycle after its address
      if (cap_valid_ff) begin
         free_ff[cap_dir_ff] <= cap_ok_ff && !mem_q_ff;
      end
   end

   // diagonals also need both orthogonal cells they pass between
   assign result.valid = (state_ff == gne_pkg::ScanDone) && !cap_valid_ff;
   assign result.node  = node_ff;
   assign result.ok[0] = free_ff[0] && free_ff[1] && free_ff[3];
   assign result.ok[1] = free_ff[1];
   assign result.ok[2] = free_ff[2] && free_ff[1] && free_ff[4];
   assign result.ok[3] = free_ff[3];
   assign result.ok[4] = free_ff[4];
   assign result.ok[5] = free_ff[5] && free_ff[6] && free_ff[3];
   assign result.ok[6] = free_ff[6];
   assign result.ok[7] = free_ff[7] && free_ff[6] && free_ff[4];

endmodule

[rtl/grid_neighbor_expansion.sv]
// ----------------------------------------------------------------------------
// grid_neighbor_expansion
// Writes cells of an occupancy grid and expands a node into eight neighbors.
// A write is stored as it is accepted. A query reads its eight neighbor cells one
// per cycle from the single-port occupancy memory; the scan then hands its
// outcome to the result emitter and can take a new query while the eight
// results are emitted, emission overlapping the next scan.
// After reset a clearing pass frees every cell with req not ready;
// cost registers reset at once and take writes throughout.
// ----------------------------------------------------------------------------
module grid_neighbor_expansion (
   input  logic                         clock,
   input  logic                         reset,
   gne_req_if.sink                      req_ch,
   gne_rsp_if.source                    rsp_ch,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [gne_pkg::CsrAddrW-1:0] paddr,
   input  logic [gne_pkg::CsrDataW-1:0] pwdata,
   output logic [gne_pkg::CsrDataW-1:0] prdata,
   output logic                         pready
);

   logic [gne_pkg::CostW-1:0]   straight_ff, diagonal_ff;
   gne_pkg::csr_index_type      csr_index;
   logic                        csr_write;

   gne_pkg::scan_result_type    scan_result;
   logic                        scan_take;

   logic                        emit_busy_ff, emit_busy_in;
   logic [gne_pkg::DirW-1:0]    emit_dir_ff, emit_dir_in;
   logic [gne_pkg::NodeW-1:0]   emit_node_ff;
   logic [gne_pkg::NumDirs-1:0] emit_ok_ff;
   logic                        emit_load;
   logic                        emit_valid;
   logic [gne_pkg::IdxW-1:0]    emit_idx;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [gne_pkg::DirW-1:0]    rsp_dir_ff;
   logic                        rsp_ok_ff;
   logic [gne_pkg::NodeW-1:0]   rsp_node_ff;
   logic [gne_pkg::CostW-1:0]   rsp_cost_ff;
   logic                        rsp_last_ff;

   // configuration registers
   assign pready    = 1'b1;
   assign csr_index = gne_pkg::csr_index_type'(paddr[2]);
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         straight_ff <= gne_pkg::StraightInit;
         diagonal_ff <= gne_pkg::DiagonalInit;
      end else if (csr_write) begin
         case (csr_index)
            gne_pkg::CsrStraightCost: straight_ff <= pwdata[gne_pkg::CostW-1:0];
            gne_pkg::CsrDiagonalCost: diagonal_ff <= pwdata[gne_pkg::CostW-1:0];
            default: straight_ff <= straight_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         gne_pkg::CsrStraightCost: prdata = gne_pkg::CsrDataW'(straight_ff);
         gne_pkg::CsrDiagonalCost: prdata = gne_pkg::CsrDataW'(diagonal_ff);
         default: prdata = '0;
      endcase
   end

   gne_grid_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .result      (scan_result),
      .result_take (scan_take)
   );

   // result emitter: eight transfers from the latched scan outcome
   assign scan_take  = scan_result.valid && !emit_busy_ff;
   assign emit_load  = emit_busy_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign emit_valid = emit_ok_ff[emit_dir_ff];
   assign emit_idx   = gne_pkg::IdxW'(emit_node_ff) + gne_pkg::neighbor_offset(emit_dir_ff)
                       - gne_pkg::CenterOff;

   always_comb begin
      emit_busy_in = emit_busy_ff;
      emit_dir_in  = emit_dir_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (scan_take) begin
         emit_busy_in = 1'b1;
         emit_dir_in  = '0;
      end else if (emit_load) begin
         emit_dir_in  = emit_dir_ff + 1'b1;
         rsp_valid_in = 1'b1;
         if (emit_dir_ff == gne_pkg::LastDir) begin
            emit_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         emit_busy_ff <= 1'b0;
         emit_dir_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         emit_busy_ff <= emit_busy_in;
         emit_dir_ff  <= emit_dir_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (scan_take) begin
         emit_node_ff <= scan_result.node;
         emit_ok_ff   <= scan_result.ok;
      end
      if (emit_load) begin
         rsp_dir_ff  <= emit_dir_ff;
         rsp_ok_ff   <= emit_valid;
         rsp_node_ff <= emit_valid ? emit_idx[gne_pkg::NodeW-1:0] : '0;
         rsp_last_ff <= (emit_dir_ff == gne_pkg::LastDir);
         if (!emit_valid) begin
            rsp_cost_ff <= '0;
         end else if (gne_pkg::is_diag(emit_dir_ff)) begin
            rsp_cost_ff <= diagonal_ff;
         end else begin
            rsp_cost_ff <= straight_ff;
         end
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.direction = rsp_dir_ff;
   assign rsp_ch.valid_res = rsp_ok_ff;
   assign rsp_ch.to_node   = rsp_node_ff;
   assign rsp_ch.step_cost = rsp_cost_ff;
   assign rsp_ch.last      = rsp_last_ff;

endmodule

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Testbench for grid_neighbor_expansion. Cell writes and neighbor queries go
// in over the request channel. Every query transfer is expanded by a local
// occupancy model into eight expected neighbor records. Each result transfer
// is compared field by field, in order, against those records. Step costs
// are reprogrammed and read back over the register port between traffic
// phases, and sender gaps and receiver stalls vary from phase to phase.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int SettleCycles = 40;
   localparam int PhaseItems   = 50;
   // ~220 items plus the clearing pass, taken many times over
   localparam int CycleLimit   = 200000;

   typedef struct packed {
      logic [gne_pkg::DirW-1:0]  direction;
      logic                      valid_res;
      logic [gne_pkg::NodeW-1:0] to_node;
      logic [gne_pkg::CostW-1:0] step_cost;
      logic                      last;
   } neighbor_type;

   logic                         clock;
   logic                         reset;
   logic                         psel;
   logic                         penable;
   logic                         pwrite;
   logic [gne_pkg::CsrAddrW-1:0] paddr;
   logic [gne_pkg::CsrDataW-1:0] pwdata;
   logic [gne_pkg::CsrDataW-1:0] prdata;
   logic                         pready;

   gne_req_if req_ch();
   gne_rsp_if rsp_ch();

   grid_neighbor_expansion dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   logic                      occupied [gne_pkg::StoreDepth];
   logic [gne_pkg::CostW-1:0] straight_cost_q;
   logic [gne_pkg::CostW-1:0] diagonal_cost_q;
   neighbor_type              pending_neighbors [$];
   int                        error_count = 0;
   int                        cycle_count = 0;
   int                        send_idle_pct = 0;
   int                        rsp_stall_pct = 0;
   int                        patch_row = 0;
   int                        patch_col = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("FAIL grid_neighbor_expansion");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // ---------------- occupancy model ----------------

   function automatic logic cell_open(input int r, input int c);
      int idx;
      if (r < 0 || c < 0 || r >= gne_pkg::GridSize || c >= gne_pkg::GridSize) return 1'b0;
      idx = r * gne_pkg::GridSize + c;
      // cells beyond the store count as blocked
      if (idx >= gne_pkg::StoreDepth) return 1'b0;
      return !occupied[idx];
   endfunction

   function automatic void expand_node(input logic [gne_pkg::NodeW-1:0] node);
      int           row;
      int           col;
      int           slot;
      int           dr;
      int           dc;
      int           tr;
      int           tc;
      logic         in_grid;
      logic         diag;
      logic         ok;
      neighbor_type n;
      in_grid = int'(node) < gne_pkg::NumCells;
      row     = in_grid ? int'(node) / gne_pkg::GridSize : 0;
      col     = in_grid ? int'(node) % gne_pkg::GridSize : 0;
      for (int d = 0; d < gne_pkg::NumDirs; d++) begin
         slot = (d < 4) ? d : d + 1;   // skip the center of the 3x3 window
         dr   = slot / 3 - 1;
         dc   = slot % 3 - 1;
         tr   = row + dr;
         tc   = col + dc;
         diag = (dr != 0) && (dc != 0);
         // no corner cutting: a diagonal needs both orthogonal cells open
         ok   = in_grid && cell_open(tr, tc) &&
                (!diag || (cell_open(tr, col) && cell_open(row, tc)));
         n.direction = gne_pkg::DirW'(d);
         n.valid_res = ok;
         n.to_node   = ok ? gne_pkg::NodeW'(tr * gne_pkg::GridSize + tc) : '0;
         n.step_cost = ok ? (diag ? diagonal_cost_q : straight_cost_q) : '0;
         n.last      = (d == gne_pkg::NumDirs - 1);
         pending_neighbors.push_back(n);
      end
   endfunction

   // ---------------- result checking ----------------

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      neighbor_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_neighbors.size() == 0) begin
            $error("unexpected result transfer: direction %0d to_node %0d",
                   rsp_ch.direction, rsp_ch.to_node);
            error_count++;
         end else begin
            want = pending_neighbors.pop_front();
            check_field("direction", want.direction, rsp_ch.direction);
            check_field("valid_res", want.valid_res, rsp_ch.valid_res);
            check_field("to_node", want.to_node, rsp_ch.to_node);
            check_field("step_cost", want.step_cost, rsp_ch.step_cost);
            check_field("last", want.last, rsp_ch.last);
         end
      end
   end

   // ---------------- drivers ----------------

   task automatic send_item(input logic cmd, input logic [gne_pkg::NodeW-1:0] node,
                            input logic blocked);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.command <= cmd;
      req_ch.node    <= node;
      req_ch.blocked <= blocked;
      do @(posedge clock); while (!req_ch.ready);
      if (cmd == gne_pkg::CmdWrite) begin
         if (int'(node) < gne_pkg::NumCells && int'(node) < gne_pkg::StoreDepth) begin
            occupied[node] = blocked;
         end
      end else begin
         expand_node(node);
      end
      @(negedge clock);
   endtask

   task automatic query(input int node);
      send_item(gne_pkg::CmdQuery, gne_pkg::NodeW'(node), 1'b0);
   endtask

   task automatic set_cell(input int node, input logic blocked);
      send_item(gne_pkg::CmdWrite, gne_pkg::NodeW'(node), blocked);
   endtask

   task automatic wait_for_results(input int settle);
      req_ch.valid <= 1'b0;
      while (pending_neighbors.size() != 0) @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   task automatic write_cost(input gne_pkg::csr_index_type idx,
                             input logic [gne_pkg::CostW-1:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= gne_pkg::CsrAddrW'(4 * int'(idx));
      pwdata  <= gne_pkg::CsrDataW'(value);
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (idx == gne_pkg::CsrStraightCost) straight_cost_q = value;
      else diagonal_cost_q = value;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic read_cost(input gne_pkg::csr_index_type idx);
      logic [gne_pkg::CostW-1:0] want;
      want = (idx == gne_pkg::CsrStraightCost) ? straight_cost_q : diagonal_cost_q;
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= gne_pkg::CsrAddrW'(4 * int'(idx));
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      check_field(idx == gne_pkg::CsrStraightCost ? "prdata straight_cost"
                                                  : "prdata diagonal_cost",
                  gne_pkg::CsrDataW'(want), prdata);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic set_costs(input logic [gne_pkg::CostW-1:0] straight,
                            input logic [gne_pkg::CostW-1:0] diagonal);
      wait_for_results(SettleCycles);
      write_cost(gne_pkg::CsrStraightCost, straight);
      write_cost(gne_pkg::CsrDiagonalCost, diagonal);
      read_cost(gne_pkg::CsrStraightCost);
      read_cost(gne_pkg::CsrDiagonalCost);
   endtask

   function automatic logic [gne_pkg::NodeW-1:0] pick_node();
      int sel;
      int r;
      int c;
      sel = $urandom_range(99);
      r   = $urandom_range(gne_pkg::GridSize - 1);
      c   = $urandom_range(gne_pkg::GridSize - 1);
      if (sel < 55) begin
         // dense patch so that writes and queries meet
         r = patch_row + $urandom_range(5);
         c = patch_col + $urandom_range(5);
      end else if (sel < 75) begin
         case ($urandom_range(3))
            0: r = 0;
            1: r = gne_pkg::GridSize - 1;
            2: c = 0;
            default: c = gne_pkg::GridSize - 1;
         endcase
      end else begin
         return gne_pkg::NodeW'($urandom_range(gne_pkg::NumCells - 1));
      end
      return gne_pkg::NodeW'(r * gne_pkg::GridSize + c);
   endfunction

   // ---------------- tests ----------------

   task automatic test_reset_costs();
      read_cost(gne_pkg::CsrStraightCost);
      read_cost(gne_pkg::CsrDiagonalCost);
   endtask

   task automatic test_open_grid();
      query(0);
      query(gne_pkg::GridSize - 1);
      query(gne_pkg::NumCells - gne_pkg::GridSize);
      query(gne_pkg::NumCells - 1);
      query(16 * gne_pkg::GridSize + 16);
      query(gne_pkg::GridSize + 1);
   endtask

   task automatic test_corner_cutting();
      int center;
      center = 16 * gne_pkg::GridSize + 16;
      // blocked right neighbor also cuts both right diagonals
      set_cell(center + 1, 1'b1);
      query(center);
      query(center + 1);
      // blocked diagonal alone leaves the orthogonals open
      set_cell(center - gne_pkg::GridSize - 1, 1'b1);
      query(center);
      set_cell(center + 1, 1'b0);
      set_cell(center - gne_pkg::GridSize - 1, 1'b0);
      // obstacles on the border
      set_cell(1, 1'b1);
      query(0);
      query(gne_pkg::GridSize);
      set_cell(1, 1'b0);
      set_cell(gne_pkg::NumCells - 1, 1'b1);
      query(gne_pkg::NumCells - 1);
      query(gne_pkg::NumCells - 2);
      set_cell(gne_pkg::NumCells - 1, 1'b0);
   endtask

   task automatic test_cost_extremes();
      set_costs('0, '1);
      query(16 * gne_pkg::GridSize + 16);
      query(0);
      set_costs('1, '0);
      query(16 * gne_pkg::GridSize + 16);
      query(gne_pkg::NumCells - 1);
   endtask

   task automatic test_random_traffic();
      logic [gne_pkg::NodeW-1:0] node;
      for (int phase = 0; phase < 4; phase++) begin
         if (phase == 3) set_costs(gne_pkg::StraightInit, gne_pkg::DiagonalInit);
         else set_costs(gne_pkg::CostW'($urandom_range(65535)),
                        gne_pkg::CostW'($urandom_range(65535)));
         case (phase)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 55;
               rsp_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 55;
            end
            default: begin
               send_idle_pct = 38;
               rsp_stall_pct = 38;
            end
         endcase
         case ($urandom_range(2))
            0: patch_row = 0;
            1: patch_row = gne_pkg::GridSize - 6;
            default: patch_row = $urandom_range(gne_pkg::GridSize - 6);
         endcase
         patch_col = $urandom_range(gne_pkg::GridSize - 6);
         for (int i = 0; i < PhaseItems; i++) begin
            // sender holds off until the block has drained
            if (phase == 2 && i == PhaseItems / 2) wait_for_results(0);
            node = pick_node();
            if ($urandom_range(99) < 40) set_cell(node, $urandom_range(99) < 55);
            else query(node);
         end
      end
   endtask

   initial begin
      reset          = 1'b1;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      req_ch.valid   = 1'b0;
      req_ch.command = gne_pkg::CmdWrite;
      req_ch.node    = '0;
      req_ch.blocked = 1'b0;
      foreach (occupied[i]) occupied[i] = 1'b0;
      straight_cost_q = gne_pkg::StraightInit;
      diagonal_cost_q = gne_pkg::DiagonalInit;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_costs();
      test_open_grid();
      test_corner_cutting();
      test_cost_extremes();
      test_random_traffic();
      wait_for_results(SettleCycles);
      if (error_count == 0) begin
         $display("PASS grid_neighbor_expansion");
      end else begin
         $display("FAIL grid_neighbor_expansion");
      end
      $finish;
   end

endmodule
